FILE: sv/apt_pkg.sv
// Shared constants, types and tables for the affine point transform.
package apt_pkg;

   // Coordinate width and number of CORDIC steps.
   localparam int COORD_WIDTH     = 24;
   localparam int TRIG_ITERATIONS = 16;
   localparam int TRIG_STEPS      = (TRIG_ITERATIONS > 24) ? 24 : TRIG_ITERATIONS;

   // Matrix term formats.
   localparam int LIN_WIDTH  = 25;
   localparam int OFF_WIDTH  = 26;
   localparam int TRIG_WIDTH = 34;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [LIN_WIDTH-1:0]   lin_type;
   typedef logic signed [OFF_WIDTH-1:0]   off_type;

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      CSR_TRANSLATE_X  = 3'd0,
      CSR_TRANSLATE_Y  = 3'd1,
      CSR_ROTATION     = 3'd2,
      CSR_SCALE_X      = 3'd3,
      CSR_SCALE_Y      = 3'd4,
      CSR_ORDER_MODE   = 3'd5
   } csr_index_type;

   // Arctangent of 2^-i in degrees times 65536.
   function automatic logic signed [22:0] atan_entry(input logic [4:0] i);
      logic signed [22:0] v;
      case (i)
         5'd0:    v = 23'sd2949120;
         5'd1:    v = 23'sd1740967;
         5'd2:    v = 23'sd919879;
         5'd3:    v = 23'sd466945;
         5'd4:    v = 23'sd234379;
         5'd5:    v = 23'sd117304;
         5'd6:    v = 23'sd58666;
         5'd7:    v = 23'sd29335;
         5'd8:    v = 23'sd14668;
         5'd9:    v = 23'sd7334;
         5'd10:   v = 23'sd3667;
         5'd11:   v = 23'sd1833;
         5'd12:   v = 23'sd917;
         5'd13:   v = 23'sd458;
         5'd14:   v = 23'sd229;
         5'd15:   v = 23'sd115;
         5'd16:   v = 23'sd57;
         5'd17:   v = 23'sd29;
         5'd18:   v = 23'sd14;
         5'd19:   v = 23'sd7;
         5'd20:   v = 23'sd4;
         5'd21:   v = 23'sd2;
         5'd22:   v = 23'sd1;
         default: v = 23'sd0;
      endcase
      return v;
   endfunction

endpackage

FILE: sv/apt_if.sv
// Stream interfaces for input points and transformed points.
interface apt_req_if
   import apt_pkg::*;
();
   logic      valid;
   logic      ready;
   coord_type point_x;
   coord_type point_y;

   modport source (output valid, output point_x, output point_y, input ready);
   modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

interface apt_rsp_if
   import apt_pkg::*;
();
   logic      valid;
   logic      ready;
   coord_type out_x;
   coord_type out_y;
   logic      saturated;

   modport source (output valid, output out_x, output out_y, output saturated, input ready);
   modport sink   (input valid, input out_x, input out_y, input saturated, output ready);
endinterface

FILE: sv/affine_point_transform_2d.sv
// Top level: matrix builder and four-stage point transform pipeline.
//
//   Channel   Direction  Handshake          Payload
//   req_ch    in         valid / ready      point_x, point_y
//   rsp_ch    out        valid / ready      out_x, out_y, saturated
//   csr_*     in         csr_we             csr_index, csr_wdata
//
// One item per clock through four register stages when rsp_ch does not stall.
// After reset or a register write the matrix is rebuilt by a sequencer:
// an angle fold, TRIG_STEPS CORDIC steps and nine multiply steps on one
// shared multiplier; req_ch.ready stays low meanwhile.
// A stall on rsp_ch freezes all stages together, so nothing is lost.
module affine_point_transform_2d
   import apt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   apt_req_if.sink            req_ch,
   apt_rsp_if.source          rsp_ch,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_wdata
);

   localparam int PROD_W = TRIG_WIDTH + LIN_WIDTH;
   localparam int ACC_W  = PROD_W + 1;
   localparam int PT_W   = LIN_WIDTH + COORD_WIDTH;
   localparam int SUM_W  = PT_W + 1;
   localparam int RES_W  = SUM_W + 1;

   localparam logic signed [PROD_W-1:0] LIN_HALF = PROD_W'(64'sd2097152);
   localparam logic signed [PROD_W-1:0] LIN_MAX  = PROD_W'(64'sd16777215);
   localparam logic signed [PROD_W-1:0] LIN_MIN  = ~LIN_MAX;
   localparam logic signed [ACC_W-1:0]  OFF_HALF = ACC_W'(64'sd536870912);
   localparam logic signed [ACC_W-1:0]  OFF_MAX  = ACC_W'(64'sd33554431);
   localparam logic signed [ACC_W-1:0]  OFF_MIN  = ~OFF_MAX;
   localparam logic signed [SUM_W-1:0]  PT_HALF  = SUM_W'(64'sd32768);
   localparam logic signed [RES_W-1:0]  OUT_MAX  =
      RES_W'((longint'(1) << (COORD_WIDTH-1)) - 1);
   localparam logic signed [RES_W-1:0]  OUT_MIN  = ~OUT_MAX;

   localparam logic signed [TRIG_WIDTH-1:0] CORDIC_START = TRIG_WIDTH'(64'sd652032874);
   localparam logic [4:0] LAST_TRIG  = 5'(TRIG_STEPS - 1);
   localparam logic [4:0] STEP_OFF_X = 5'd6;
   localparam logic [4:0] STEP_OFF_Y = 5'd8;

   typedef enum logic [1:0] {S_ANGLE, S_CORDIC, S_TERMS, S_READY} state_type;

   // Configuration registers.
   logic signed [23:0] tx_ff, ty_ff;
   logic [15:0]        ang_ff, sx_ff, sy_ff;
   logic [1:0]         mode_ff;
   logic               rebuild;

   assign rebuild = csr_we && (csr_index <= CSR_ORDER_MODE);

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_ff   <= 24'sd76800;
         ty_ff   <= 24'sd51200;
         ang_ff  <= 16'd0;
         sx_ff   <= 16'd384;
         sy_ff   <= 16'd384;
         mode_ff <= 2'd0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TRANSLATE_X: tx_ff   <= $signed(csr_wdata);
            CSR_TRANSLATE_Y: ty_ff   <= $signed(csr_wdata);
            CSR_ROTATION:    ang_ff  <= csr_wdata[15:0];
            CSR_SCALE_X:     sx_ff   <= csr_wdata[15:0];
            CSR_SCALE_Y:     sy_ff   <= csr_wdata[15:0];
            CSR_ORDER_MODE:  mode_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // Angle fold into [-90, 90] degrees, in degrees times 65536.
   logic [15:0]        ang_red;
   logic signed [26:0] d_wrap, d_fold;
   logic               fold_neg;

   always_comb begin
      ang_red  = (ang_ff >= 16'd46080) ? ang_ff - 16'd46080 : ang_ff;
      d_wrap   = $signed({2'b00, ang_red, 9'b0});
      if (d_wrap > 27'sd11796480) d_wrap = d_wrap - 27'sd23592960;
      d_fold   = d_wrap;
      fold_neg = 1'b0;
      if (d_wrap > 27'sd5898240) begin
         d_fold   = d_wrap - 27'sd11796480;
         fold_neg = 1'b1;
      end else if (d_wrap < -27'sd5898240) begin
         d_fold   = d_wrap + 27'sd11796480;
         fold_neg = 1'b1;
      end
   end

   // Sequencer registers.
   state_type               state_ff;
   logic [4:0]              step_ff;
   logic signed [26:0]      d_ff;
   logic                    neg_ff;
   logic signed [TRIG_WIDTH-1:0] cx_ff, cy_ff;
   logic signed [PROD_W-1:0] prod_ff, acc_ff;
   lin_type                 lin_ff [4];
   off_type                 off_ff [2];

   // One CORDIC step.
   logic signed [TRIG_WIDTH-1:0] sh_x, sh_y, cx_in, cy_in;
   logic signed [26:0]           d_in;
   logic signed [26:0]           atan_val;

   always_comb begin
      sh_x     = cx_ff >>> step_ff;
      sh_y     = cy_ff >>> step_ff;
      atan_val = 27'(atan_entry(step_ff));
      if (!d_ff[26]) begin
         cx_in = cx_ff - sh_y;
         cy_in = cy_ff + sh_x;
         d_in  = d_ff - atan_val;
      end else begin
         cx_in = cx_ff + sh_y;
         cy_in = cy_ff - sh_x;
         d_in  = d_ff + atan_val;
      end
   end

   // Operand selection for the shared term multiplier.
   logic signed [TRIG_WIDTH-1:0] cos_v, sin_v, mul_a;
   logic signed [LIN_WIDTH-1:0]  fx, fy, mul_b;
   logic                         scaled, rot_offset;

   always_comb begin
      cos_v      = neg_ff ? -cx_ff : cx_ff;
      sin_v      = neg_ff ? -cy_ff : cy_ff;
      scaled     = (mode_ff == 2'd0) || (mode_ff == 2'd3);
      rot_offset = (mode_ff == 2'd2);
      fx         = scaled ? $signed({9'b0, sx_ff}) : 25'sd256;
      fy         = scaled ? $signed({9'b0, sy_ff}) : 25'sd256;
      case (step_ff[2:0])
         3'd0, 3'd3, 3'd4, 3'd7: mul_a = cos_v;
         3'd1:                   mul_a = -sin_v;
         default:                mul_a = sin_v;
      endcase
      case (step_ff[2:0])
         3'd0, 3'd2: mul_b = fx;
         3'd1, 3'd3: mul_b = fy;
         3'd4, 3'd6: mul_b = LIN_WIDTH'(tx_ff);
         default:    mul_b = LIN_WIDTH'(ty_ff);
      endcase
   end

   // Rounding and saturation of the terms.
   logic signed [PROD_W-1:0] lin_rnd;
   logic signed [ACC_W-1:0]  off_sum, off_rnd;
   lin_type                  lin_sat;
   off_type                  off_sat;

   always_comb begin
      lin_rnd = (prod_ff + LIN_HALF) >>> 22;
      if (lin_rnd > LIN_MAX)      lin_sat = LIN_MAX[LIN_WIDTH-1:0];
      else if (lin_rnd < LIN_MIN) lin_sat = LIN_MIN[LIN_WIDTH-1:0];
      else                        lin_sat = lin_rnd[LIN_WIDTH-1:0];
      if (step_ff == STEP_OFF_X) off_sum = ACC_W'(acc_ff) - ACC_W'(prod_ff);
      else                       off_sum = ACC_W'(acc_ff) + ACC_W'(prod_ff);
      off_rnd = (off_sum + OFF_HALF) >>> 30;
      if (off_rnd > OFF_MAX)      off_sat = OFF_MAX[OFF_WIDTH-1:0];
      else if (off_rnd < OFF_MIN) off_sat = OFF_MIN[OFF_WIDTH-1:0];
      else                        off_sat = off_rnd[OFF_WIDTH-1:0];
   end

   // Matrix builder sequence.
   always_ff @(posedge clock) begin
      if (reset || rebuild) begin
         state_ff <= S_ANGLE;
         step_ff  <= 5'd0;
      end else begin
         case (state_ff)
            S_ANGLE: begin
               d_ff     <= d_fold;
               neg_ff   <= fold_neg;
               cx_ff    <= CORDIC_START;
               cy_ff    <= '0;
               step_ff  <= 5'd0;
               state_ff <= S_CORDIC;
            end
            S_CORDIC: begin
               cx_ff <= cx_in;
               cy_ff <= cy_in;
               d_ff  <= d_in;
               if (step_ff == LAST_TRIG) begin
                  step_ff  <= 5'd0;
                  state_ff <= S_TERMS;
               end else begin
                  step_ff <= step_ff + 5'd1;
               end
            end
            S_TERMS: begin
               prod_ff <= mul_a * mul_b;
               step_ff <= step_ff + 5'd1;
               case (step_ff)
                  5'd1, 5'd2, 5'd3, 5'd4: lin_ff[step_ff[1:0] - 2'd1] <= lin_sat;
                  5'd5, 5'd7:             acc_ff <= prod_ff;
                  STEP_OFF_X: off_ff[0] <= rot_offset ? off_sat : OFF_WIDTH'(tx_ff);
                  STEP_OFF_Y: begin
                     off_ff[1] <= rot_offset ? off_sat : OFF_WIDTH'(ty_ff);
                     state_ff  <= S_READY;
                  end
                  default: ;
               endcase
            end
            S_READY: ;
            default: state_ff <= S_ANGLE;
         endcase
      end
   end

   // Point pipeline; all stages move together when the output can advance.
   logic                     en;
   logic                     v1_ff, v2_ff, v3_ff, out_v_ff;
   coord_type                x1_ff, y1_ff;
   logic signed [PT_W-1:0]   p00_ff, p01_ff, p10_ff, p11_ff;
   logic signed [RES_W-1:0]  rx_ff, ry_ff;
   logic signed [SUM_W-1:0]  sx_sum, sy_sum;
   logic signed [RES_W-1:0]  rx_in, ry_in;
   coord_type                ox_ff, oy_ff, ox_in, oy_in;
   logic                     sat_ff, hit_x, hit_y;

   assign en           = !out_v_ff || rsp_ch.ready;
   assign req_ch.ready = en && (state_ff == S_READY);

   always_comb begin
      sx_sum = SUM_W'(p00_ff) + SUM_W'(p01_ff) + PT_HALF;
      sy_sum = SUM_W'(p10_ff) + SUM_W'(p11_ff) + PT_HALF;
      rx_in  = RES_W'(sx_sum >>> 16) + RES_W'(off_ff[0]);
      ry_in  = RES_W'(sy_sum >>> 16) + RES_W'(off_ff[1]);
      hit_x  = (rx_ff > OUT_MAX) || (rx_ff < OUT_MIN);
      hit_y  = (ry_ff > OUT_MAX) || (ry_ff < OUT_MIN);
      if (rx_ff > OUT_MAX)      ox_in = OUT_MAX[COORD_WIDTH-1:0];
      else if (rx_ff < OUT_MIN) ox_in = OUT_MIN[COORD_WIDTH-1:0];
      else                      ox_in = rx_ff[COORD_WIDTH-1:0];
      if (ry_ff > OUT_MAX)      oy_in = OUT_MAX[COORD_WIDTH-1:0];
      else if (ry_ff < OUT_MIN) oy_in = OUT_MIN[COORD_WIDTH-1:0];
      else                      oy_in = ry_ff[COORD_WIDTH-1:0];
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (en) begin
         v1_ff    <= req_ch.valid && (state_ff == S_READY);
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         out_v_ff <= v3_ff;
      end
   end

   // Payload stages: capture, products, sums with offset, saturation.
   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff  <= req_ch.point_x;
         y1_ff  <= req_ch.point_y;
         p00_ff <= lin_ff[0] * x1_ff;
         p01_ff <= lin_ff[1] * y1_ff;
         p10_ff <= lin_ff[2] * x1_ff;
         p11_ff <= lin_ff[3] * y1_ff;
         rx_ff  <= rx_in;
         ry_ff  <= ry_in;
         ox_ff  <= ox_in;
         oy_ff  <= oy_in;
         sat_ff <= hit_x || hit_y;
      end
   end

   assign rsp_ch.valid     = out_v_ff;
   assign rsp_ch.out_x     = ox_ff;
   assign rsp_ch.out_y     = oy_ff;
   assign rsp_ch.saturated = sat_ff;

endmodule

FILE: tb/sv/tb.sv
// Testbench for the 2D affine point transform: streams points and checks each output.
`timescale 1ns / 1ps
module tb;
   import apt_pkg::*;

   logic clock;
   logic reset;
   logic csr_we;
   logic [2:0] csr_index;
   logic [23:0] csr_wdata;

   apt_req_if req_ch ();
   apt_rsp_if rsp_ch ();

   affine_point_transform_2d u_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   typedef struct packed {
      logic signed [23:0] px;
      logic signed [23:0] py;
   } point_type;

   typedef struct packed {
      logic signed [23:0] ox;
      logic signed [23:0] oy;
      logic sat;
   } xform_type;

   // Shadow copy of the registers and the composite matrix.
   logic signed [23:0] sh_tx, sh_ty;
   logic [15:0] sh_ang, sh_sx, sh_sy;
   logic [1:0] sh_mode;
   longint m_lin [4];
   longint m_off [2];

   point_type pending_points[$];
   xform_type expected_points[$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_rsp = 0;
   bit accepted_last = 0;
   longint cycles = 0;

   function automatic longint asr_l(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint round_shift(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clip(longint v, int bits);
      longint hi = (longint'(1) <<< (bits - 1)) - 1;
      longint lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // Rebuild the matrix from the shadow registers with a CORDIC of its own.
   task automatic build_matrix();
      longint atans [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                             29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
                             14, 7, 4, 2, 1, 0};
      longint d, cx, sy, t, c, s, tx, ty, sxl, syl;
      bit flip;
      int n;
      d = longint'(sh_ang % 46080) * 512;
      cx = 652032874;
      sy = 0;
      flip = 0;
      n = (TRIG_ITERATIONS > 24) ? 24 : TRIG_ITERATIONS;
      if (d > 11796480) d -= 23592960;
      if (d > 5898240) begin
         d -= 11796480;
         flip = 1;
      end else if (d < -5898240) begin
         d += 11796480;
         flip = 1;
      end
      for (int i = 0; i < n; i++) begin
         if (d >= 0) begin
            t = cx - asr_l(sy, i); sy = sy + asr_l(cx, i); cx = t; d -= atans[i];
         end else begin
            t = cx + asr_l(sy, i); sy = sy - asr_l(cx, i); cx = t; d += atans[i];
         end
      end
      c = flip ? -cx : cx;
      s = flip ? -sy : sy;
      tx = sh_tx;
      ty = sh_ty;
      sxl = sh_sx;
      syl = sh_sy;
      if (sh_mode == 0 || sh_mode == 3) begin
         m_lin[0] = clip(round_shift(c * sxl, 22), 25);
         m_lin[1] = clip(round_shift(-s * syl, 22), 25);
         m_lin[2] = clip(round_shift(s * sxl, 22), 25);
         m_lin[3] = clip(round_shift(c * syl, 22), 25);
      end else begin
         m_lin[0] = clip(round_shift(c, 14), 25);
         m_lin[1] = clip(round_shift(-s, 14), 25);
         m_lin[2] = clip(round_shift(s, 14), 25);
         m_lin[3] = m_lin[0];
      end
      if (sh_mode == 2) begin
         m_off[0] = clip(round_shift(c * tx - s * ty, 30), 26);
         m_off[1] = clip(round_shift(s * tx + c * ty, 30), 26);
      end else begin
         m_off[0] = tx;
         m_off[1] = ty;
      end
   endtask

   function automatic xform_type transform_point(point_type p);
      xform_type r;
      longint x = p.px, y = p.py, ox, oy;
      ox = round_shift(m_lin[0] * x + m_lin[1] * y, 16) + m_off[0];
      oy = round_shift(m_lin[2] * x + m_lin[3] * y, 16) + m_off[1];
      r.sat = (ox != clip(ox, COORD_WIDTH)) || (oy != clip(oy, COORD_WIDTH));
      r.ox = 24'(clip(ox, COORD_WIDTH));
      r.oy = 24'(clip(oy, COORD_WIDTH));
      return r;
   endfunction

   // Clock and cycle limit.
   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 2000000) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Driver: offers queued points, changing inputs at the falling edge.
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 0;
      end else if (req_ch.valid && !accepted_last) begin
         // hold the current item until it is taken
      end else if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
         req_ch.valid <= 1;
         req_ch.point_x <= pending_points[0].px;
         req_ch.point_y <= pending_points[0].py;
         expected_points.insert(expected_points.size(), transform_point(pending_points[0]));
         void'(pending_points.pop_front());
      end else begin
         req_ch.valid <= 0;
      end
      rsp_ch.ready <= !hold_rsp && ($urandom_range(99) >= recv_stall_pct);
   end

   // Acceptance flag for the driver, sampled at the rising edge.
   always @(posedge clock) begin
      accepted_last <= req_ch.valid && req_ch.ready;
   end

   // Monitor: compares each output item with the oldest expectation.
   always @(posedge clock) begin
      xform_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_points.size() == 0) begin
            $display("%0t: unexpected item x=%0d y=%0d sat=%0d", $time,
                     rsp_ch.out_x, rsp_ch.out_y, rsp_ch.saturated);
            errors++;
         end else begin
            e = expected_points.pop_front();
            if (rsp_ch.out_x !== e.ox || rsp_ch.out_y !== e.oy ||
                rsp_ch.saturated !== e.sat) begin
               $display("%0t: expected x=%0d y=%0d sat=%0d, got x=%0d y=%0d sat=%0d",
                        $time, e.ox, e.oy, e.sat, rsp_ch.out_x, rsp_ch.out_y,
                        rsp_ch.saturated);
               errors++;
            end
         end
      end
   end

   task automatic wait_drained();
      while (pending_points.size() > 0 || req_ch.valid || expected_points.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [23:0] val);
      @(negedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 0;
      case (idx)
         CSR_TRANSLATE_X: sh_tx = val;
         CSR_TRANSLATE_Y: sh_ty = val;
         CSR_ROTATION:    sh_ang = val[15:0];
         CSR_SCALE_X:     sh_sx = val[15:0];
         CSR_SCALE_Y:     sh_sy = val[15:0];
         CSR_ORDER_MODE:  sh_mode = val[1:0];
         default: ;
      endcase
      build_matrix();
   endtask

   function automatic logic [23:0] rand_coord();
      case ($urandom_range(5))
         0: return 24'(24'h7FFFFF - $urandom_range(3));
         1: return 24'(24'h800000 + $urandom_range(3));
         2: return 24'($urandom_range(2047) - 1024);
         default: return 24'($urandom());
      endcase
   endfunction

   task automatic add_point(logic [23:0] x, logic [23:0] y);
      point_type p;
      p.px = x;
      p.py = y;
      pending_points.insert(pending_points.size(), p);
   endtask

   // Stimulus: directed points, then random phases under several settings.
   initial begin
      int phase_items;
      reset = 1;
      csr_we = 0;
      csr_index = CSR_TRANSLATE_X;
      csr_wdata = '0;
      sh_tx = 24'sd76800;
      sh_ty = 24'sd51200;
      sh_ang = 16'd0;
      sh_sx = 16'd384;
      sh_sy = 16'd384;
      sh_mode = 2'd0;
      build_matrix();
      repeat (8) @(posedge clock);
      reset <= 0;

      // Directed: field extremes under the reset matrix.
      add_point(24'h000000, 24'h000000);
      add_point(24'h7FFFFF, 24'h7FFFFF);
      add_point(24'h800000, 24'h800000);
      add_point(24'h7FFFFF, 24'h800000);
      add_point(24'h800000, 24'h7FFFFF);
      add_point(24'hFFFFFF, 24'h000001);
      add_point(24'h000100, 24'hFFFF00);
      wait_drained();
      // Each order mode, angles near the fold points and beyond the range.
      write_reg(CSR_ROTATION, 24'd11520);
      add_point(24'h001000, 24'h002000);
      wait_drained();
      write_reg(CSR_ORDER_MODE, 24'd1);
      write_reg(CSR_ROTATION, 24'd23041);
      add_point(24'h001000, 24'h7FFFFF);
      wait_drained();
      write_reg(CSR_ORDER_MODE, 24'd2);
      write_reg(CSR_TRANSLATE_X, 24'h7FFFFF);
      write_reg(CSR_TRANSLATE_Y, 24'h800000);
      write_reg(CSR_ROTATION, 24'h00FFFF);
      add_point(24'h000500, 24'hFFF000);
      add_point(24'h7FFFFF, 24'h7FFFFF);
      wait_drained();
      write_reg(CSR_ORDER_MODE, 24'd3);
      write_reg(CSR_SCALE_X, 24'h00FFFF);
      write_reg(CSR_SCALE_Y, 24'h000000);
      write_reg(CSR_ROTATION, 24'd34560);
      add_point(24'h7FFFFF, 24'h800000);
      add_point(24'h012345, 24'hFEDCBA);
      wait_drained();
      write_reg(csr_index_type'(3'd7), 24'h123456);
      add_point(24'h000800, 24'h000800);
      wait_drained();

      // Random phases: new settings, then idling pattern.
      for (int ph = 0; ph < 16; ph++) begin
         write_reg(CSR_TRANSLATE_X, (ph == 3) ? 24'h800000 : 24'($urandom()));
         write_reg(CSR_TRANSLATE_Y, (ph == 4) ? 24'h7FFFFF : 24'($urandom()));
         write_reg(CSR_ROTATION, (ph == 5) ? 24'h00FFFF : 24'($urandom_range(46079)));
         write_reg(CSR_SCALE_X, (ph == 6) ? 24'h00FFFF : 24'($urandom_range(1023)));
         write_reg(CSR_SCALE_Y, (ph == 6) ? 24'h000000 : 24'($urandom_range(1023)));
         write_reg(CSR_ORDER_MODE, 24'(ph % 4));
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
            default: begin send_idle_pct = 12; recv_stall_pct = 12; end
         endcase
         phase_items = 114;
         for (int k = 0; k < phase_items; k++) add_point(rand_coord(), rand_coord());
         if (ph == 8) begin
            // Long receiver hold-off while the sender keeps offering.
            hold_rsp = 1;
            repeat (200) @(posedge clock);
            hold_rsp = 0;
         end
         wait_drained();
      end

      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
